// ===== src/lfdrc_pkg.sv =====
`default_nettype none

package lfdrc_pkg;

   // default run counter width
   localparam int LFDRC_COUNT_WIDTH = 16;

   // width of the repeat count field on the result channel
   localparam int REPEAT_WIDTH = 16;

   // frame layout
   localparam int FRAME_WIDTH   = 11;
   localparam int OPERAND_WIDTH = 8;
   localparam int MSG_WIDTH     = 6;

   // item kinds
   localparam logic KIND_FRAME = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   // dense message class numbering
   typedef enum logic [MSG_WIDTH-1:0] {
      MSG_DAB, MSG_DAB_SRQ, MSG_END, MSG_END_SRQ, MSG_PPE, MSG_NUL, MSG_GTL, MSG_SDC,
      MSG_PPD, MSG_GET, MSG_ELN, MSG_CMD, MSG_DDL, MSG_DDT, MSG_NOP, MSG_LLO,
      MSG_DCL, MSG_PPU, MSG_EAR, MSG_IFC, MSG_REN, MSG_NRE, MSG_AAU, MSG_LPD,
      MSG_UNL, MSG_LAD, MSG_UNT, MSG_TAD, MSG_SAD, MSG_RFC, MSG_ETO, MSG_ETE,
      MSG_NRD, MSG_SDA, MSG_SST, MSG_SDI, MSG_SAI, MSG_TCT, MSG_RDY, MSG_AAD,
      MSG_IAA, MSG_AEP, MSG_IEP, MSG_ZES, MSG_AES, MSG_IES, MSG_AMP, MSG_IMP,
      MSG_IDY, MSG_IDY_SRQ
   } msg_code_type;

   // one decoded frame
   typedef struct packed {
      msg_code_type              msg;
      logic [OPERAND_WIDTH-1:0]  op;
   } dec_type;

   // one record: modified flag and decoded pair
   typedef struct packed {
      logic     modified;
      dec_type  in_dec;
      dec_type  out_dec;
   } record_type;

endpackage

`default_nettype wire

// ===== src/loop_frame_decode_run_collapse_core.sv =====
// pipeline: a frame or flush beat passes the input register before it reaches the run
//   logic; an emitted run is registered once more before it reaches the result port
// throughput: one beat per cycle unless rsp_stall holds; set by decode and run compare
// reset: synchronous, active high; clears logging enable, held record and run count
`default_nettype none

module loop_frame_decode_run_collapse_core
   import lfdrc_pkg::*;
#(
   parameter int COUNT_WIDTH = LFDRC_COUNT_WIDTH
)(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_wr_en,
   input  wire logic                      csr_wr_data,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic                      req_kind,
   input  wire logic [FRAME_WIDTH-1:0]    req_rx_frame,
   input  wire logic [FRAME_WIDTH-1:0]    req_tx_frame,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic                           rsp_was_modified,
   output logic [MSG_WIDTH-1:0]           rsp_in_message,
   output logic [OPERAND_WIDTH-1:0]       rsp_in_operand,
   output logic [MSG_WIDTH-1:0]           rsp_out_message,
   output logic [OPERAND_WIDTH-1:0]       rsp_out_operand,
   output logic [REPEAT_WIDTH-1:0]        rsp_repeat_count
);

   logic                    logging_ff;
   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_kind_ff;
   logic [FRAME_WIDTH-1:0]  s1_rx_frame_ff;
   logic [FRAME_WIDTH-1:0]  s1_tx_frame_ff;
   logic                    accept;
   logic                    ready;
   logic                    go;
   dec_type                 in_dec;
   dec_type                 out_dec;
   record_type              rec;
   record_type              rsp_rec;

   // logging enable register
   always_ff @(posedge clock) begin
      if (reset) begin
         logging_ff <= 1'b0;
      end else if (csr_wr_en) begin
         logging_ff <= csr_wr_data;
      end
   end

   // input register
   assign req_stall   = s1_valid_ff && !ready;
   assign accept      = req_valid && !req_stall;
   assign s1_valid_in = accept || (s1_valid_ff && !ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff     <= req_kind;
         s1_rx_frame_ff <= req_rx_frame;
         s1_tx_frame_ff <= req_tx_frame;
      end
   end

   // decode both frames
   lfdrc_frame_decode u_dec_in (
      .frame (s1_rx_frame_ff),
      .dec   (in_dec)
   );

   lfdrc_frame_decode u_dec_out (
      .frame (s1_tx_frame_ff),
      .dec   (out_dec)
   );

   assign rec = {(s1_rx_frame_ff != s1_tx_frame_ff), in_dec, out_dec};

   // beats are dropped without effect while logging is off
   assign go = s1_valid_ff && ready && logging_ff;

   lfdrc_run_merge #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .kind      (s1_kind_ff),
      .rec       (rec),
      .ready     (ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_rec   (rsp_rec),
      .rsp_count (rsp_repeat_count)
   );

   assign rsp_was_modified = rsp_rec.modified;
   assign rsp_in_message   = rsp_rec.in_dec.msg;
   assign rsp_in_operand   = rsp_rec.in_dec.op;
   assign rsp_out_message  = rsp_rec.out_dec.msg;
   assign rsp_out_operand  = rsp_rec.out_dec.op;

endmodule

`default_nettype wire

// ===== src/lfdrc_frame_decode.sv =====
`default_nettype none

module lfdrc_frame_decode
   import lfdrc_pkg::*;
(
   input  wire logic [FRAME_WIDTH-1:0] frame,
   output dec_type                     dec
);

   logic [2:0] frame_class;
   logic [7:0] n;
   logic [4:0] a;

   assign frame_class = frame[10:8];
   assign n           = frame[7:0];
   assign a           = n[4:0];

   // message class and operand from class bits and payload
   always_comb begin
      dec.msg = MSG_DAB;
      dec.op  = '0;
      unique case (frame_class)
         3'd0: begin
            dec.msg = MSG_DAB;
            dec.op  = n;
         end
         3'd1: dec.msg = MSG_DAB_SRQ;
         3'd2: dec.msg = MSG_END;
         3'd3: dec.msg = MSG_END_SRQ;
         3'd4: begin
            // command frames
            priority if (n[6:4] == 3'b000) begin
               if (n[7]) begin
                  dec.msg = MSG_PPE;
                  dec.op  = {4'd0, n[3:0]};
               end else begin
                  unique case (n)
                     8'h00:   dec.msg = MSG_NUL;
                     8'h01:   dec.msg = MSG_GTL;
                     8'h04:   dec.msg = MSG_SDC;
                     8'h05:   dec.msg = MSG_PPD;
                     8'h08:   dec.msg = MSG_GET;
                     8'h0F:   dec.msg = MSG_ELN;
                     default: begin
                        dec.msg = MSG_CMD;
                        dec.op  = n;
                     end
                  endcase
               end
            end else if (n[7:5] == 3'b101) begin
               dec.msg = MSG_DDL;
               dec.op  = {3'd0, a};
            end else if (n[7:5] == 3'b110) begin
               dec.msg = MSG_DDT;
               dec.op  = {3'd0, a};
            end else if (n[6:4] == 3'b001) begin
               unique case (n)
                  8'h10:   dec.msg = MSG_NOP;
                  8'h11:   dec.msg = MSG_LLO;
                  8'h14:   dec.msg = MSG_DCL;
                  8'h15:   dec.msg = MSG_PPU;
                  8'h18:   dec.msg = MSG_EAR;
                  8'h90:   dec.msg = MSG_IFC;
                  8'h92:   dec.msg = MSG_REN;
                  8'h93:   dec.msg = MSG_NRE;
                  8'h9A:   dec.msg = MSG_AAU;
                  8'h9B:   dec.msg = MSG_LPD;
                  default: begin
                     dec.msg = MSG_CMD;
                     dec.op  = n;
                  end
               endcase
            end else if (n[7:5] == 3'b001) begin
               if (a == 5'h1F) begin
                  dec.msg = MSG_UNL;
               end else begin
                  dec.msg = MSG_LAD;
                  dec.op  = {3'd0, a};
               end
            end else if (n[7:5] == 3'b010) begin
               if (a == 5'h1F) begin
                  dec.msg = MSG_UNT;
               end else begin
                  dec.msg = MSG_TAD;
                  dec.op  = {3'd0, a};
               end
            end else if (n[7:5] == 3'b011) begin
               dec.msg = MSG_SAD;
               dec.op  = {3'd0, a};
            end else begin
               dec.msg = MSG_CMD;
               dec.op  = n;
            end
         end
         3'd5: begin
            // ready frames
            priority if (n == 8'h00) begin
               dec.msg = MSG_RFC;
            end else if (n[7:6] == 2'b01) begin
               unique case (n)
                  8'h40:   dec.msg = MSG_ETO;
                  8'h41:   dec.msg = MSG_ETE;
                  8'h42:   dec.msg = MSG_NRD;
                  8'h60:   dec.msg = MSG_SDA;
                  8'h61:   dec.msg = MSG_SST;
                  8'h62:   dec.msg = MSG_SDI;
                  8'h63:   dec.msg = MSG_SAI;
                  8'h64:   dec.msg = MSG_TCT;
                  default: begin
                     dec.msg = MSG_RDY;
                     dec.op  = n;
                  end
               endcase
            end else if (n[7]) begin
               unique case (n[6:5])
                  2'b00: begin
                     if (a == 5'h1F) begin
                        dec.msg = MSG_IAA;
                     end else begin
                        dec.msg = MSG_AAD;
                        dec.op  = {3'd0, a};
                     end
                  end
                  2'b01: begin
                     if (a == 5'h1F) begin
                        dec.msg = MSG_IEP;
                     end else begin
                        dec.msg = MSG_AEP;
                        dec.op  = {3'd0, a};
                     end
                  end
                  2'b10: begin
                     priority if (a == 5'h00) begin
                        dec.msg = MSG_ZES;
                     end else if (a == 5'h1F) begin
                        dec.msg = MSG_IES;
                     end else begin
                        dec.msg = MSG_AES;
                        dec.op  = {3'd0, a};
                     end
                  end
                  default: begin
                     if (a == 5'h1F) begin
                        dec.msg = MSG_IMP;
                     end else begin
                        dec.msg = MSG_AMP;
                        dec.op  = {3'd0, a};
                     end
                  end
               endcase
            end else begin
               dec.msg = MSG_RDY;
               dec.op  = n;
            end
         end
         3'd6: begin
            dec.msg = MSG_IDY;
            dec.op  = n;
         end
         default: begin
            dec.msg = MSG_IDY_SRQ;
            dec.op  = n;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== src/lfdrc_run_merge.sv =====
`default_nettype none

module lfdrc_run_merge
   import lfdrc_pkg::*;
#(
   parameter int COUNT_WIDTH = LFDRC_COUNT_WIDTH
)(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    go,
   input  wire logic                    kind,
   input  wire record_type              rec,
   output logic                         ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output record_type                   rsp_rec,
   output logic [REPEAT_WIDTH-1:0]      rsp_count
);

   // the run counter never needs more bits than the repeat count field
   localparam int RUN_W = (COUNT_WIDTH < REPEAT_WIDTH) ? COUNT_WIDTH : REPEAT_WIDTH;

   record_type               held_ff, held_in;
   logic [RUN_W-1:0]         run_ff, run_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   record_type               rsp_rec_ff;
   logic [REPEAT_WIDTH-1:0]  rsp_count_ff;
   logic                     emit;
   logic                     holding;
   logic                     full;

   assign holding = (run_ff != '0);
   assign full    = (run_ff == {RUN_W{1'b1}});
   assign ready   = !rsp_valid_ff || !rsp_stall;

   // run update and emit decision
   always_comb begin
      held_in = held_ff;
      run_in  = run_ff;
      emit    = 1'b0;
      if (go) begin
         if (kind == KIND_FLUSH) begin
            if (holding) begin
               emit    = 1'b1;
               run_in  = '0;
               held_in = '0;
            end
         end else if (holding && (rec == held_ff)) begin
            if (full) begin
               emit   = 1'b1;
               run_in = RUN_W'(1);
            end else begin
               run_in = run_ff + RUN_W'(1);
            end
         end else begin
            emit    = holding;
            held_in = rec;
            run_in  = RUN_W'(1);
         end
      end
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);

   // run state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         run_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result beat payload
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_rec_ff   <= held_ff;
         rsp_count_ff <= REPEAT_WIDTH'(run_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_rec   = rsp_rec_ff;
   assign rsp_count = rsp_count_ff;

`ifndef ASSERT_OFF
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_count_ff != '0))
      else $error("result beat with zero repeat count");

   a_empty_clear: assert property (@(posedge clock) disable iff (reset)
      (run_ff == '0) |-> (held_ff == '0))
      else $error("record held with empty run");

   a_flush_emits: assert property (@(posedge clock) disable iff (reset)
      (go && (kind == KIND_FLUSH) && holding) |=> (rsp_valid_ff && (run_ff == '0)))
      else $error("flush of held run did not emit");

   a_frame_holds: assert property (@(posedge clock) disable iff (reset)
      (go && (kind == KIND_FRAME)) |=> (run_ff != '0))
      else $error("frame beat left no run held");
`endif

endmodule

`default_nettype wire
